FILE: hw/rtl/cpu8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_pkg
// Shared beat types, operation codes and register codes for the 8-bit ALU
// with its register file.
// ----------------------------------------------------------------------------
package cpu8_pkg;

  // Operation class carried in the func field.
  localparam logic [1:0] FUNC_ALU      = 2'd0;
  localparam logic [1:0] FUNC_INCDEC   = 2'd1;
  localparam logic [1:0] FUNC_LOAD_REG = 2'd2;
  localparam logic [1:0] FUNC_LOAD_FLG = 2'd3;

  // ALU group operation, opcode bits 5..3.
  localparam logic [2:0] ALU_ADD = 3'd0;
  localparam logic [2:0] ALU_ADC = 3'd1;
  localparam logic [2:0] ALU_SUB = 3'd2;
  localparam logic [2:0] ALU_SBC = 3'd3;
  localparam logic [2:0] ALU_AND = 3'd4;
  localparam logic [2:0] ALU_XOR = 3'd5;
  localparam logic [2:0] ALU_OR  = 3'd6;
  localparam logic [2:0] ALU_CP  = 3'd7;

  // INC/DEC kind, opcode bits 2..0. Any other kind decrements.
  localparam logic [2:0] KIND_INC = 3'd4;

  // Register codes.
  localparam logic [2:0] REG_B   = 3'd0;
  localparam logic [2:0] REG_MEM = 3'd6;
  localparam logic [2:0] REG_A   = 3'd7;

  localparam int unsigned NUM_REGS = 8;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] opcode;
    logic [7:0] mem_value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] result;
    logic [2:0] dest;
    logic       dest_written;
    logic       mem_write;
    logic       zero_flag;
    logic       sub_flag;
    logic       half_flag;
    logic       carry_flag;
  } out_beat_t;

  // Flags packed as Z, N, H, C from bit 3 down to bit 0.
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // State update produced by the execute logic for one beat.
  typedef struct packed {
    logic       reg_we;
    logic [2:0] reg_idx;
    logic [7:0] reg_data;
    flags_t     flags;
  } wb_t;

endpackage

FILE: hw/rtl/cpu8_rf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_rf
// Register file B..L and A plus the flag register, with one selectable
// read port, a fixed read of A and one write port.
// ----------------------------------------------------------------------------
module cpu8_rf
  import cpu8_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       we,
  input  wb_t        wb,
  input  logic [2:0] rd_idx,
  output logic [7:0] rd_data,
  output logic [7:0] a_data,
  output flags_t     flags
);

  logic [7:0] regs [NUM_REGS];

  // Entry 6 is never written by the execute logic and stays zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs  <= '{default: 8'd0};
      flags <= '0;
    end else if (we) begin
      if (wb.reg_we) begin
        regs[wb.reg_idx] <= wb.reg_data;
      end
      flags <= wb.flags;
    end
  end

  assign rd_data = regs[rd_idx];
  assign a_data  = regs[REG_A];

endmodule

FILE: hw/rtl/cpu8_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_exec
// Combinational execute logic: ALU group, INC/DEC, register and flag loads.
// ----------------------------------------------------------------------------
module cpu8_exec
  import cpu8_pkg::*;
(
  input  in_beat_t   beat,
  input  logic [7:0] operand,
  input  logic [7:0] a_val,
  input  flags_t     flags,
  output out_beat_t  res,
  output wb_t        wb
);

  logic [2:0] kind;
  logic [2:0] src;
  logic [7:0] b_val;
  logic [7:0] v_val;
  logic       cin;
  logic       ci;
  logic [8:0] sum9;
  logic [4:0] sum5;
  logic [8:0] dif9;
  logic [4:0] dif5;
  logic [7:0] r;
  flags_t     f;

  assign kind  = beat.opcode[5:3];
  assign src   = beat.opcode[2:0];
  assign cin   = flags.c;
  assign b_val = (src == REG_MEM) ? beat.mem_value : operand;
  assign v_val = (kind == REG_MEM) ? beat.mem_value : operand;
  assign ci    = ((kind == ALU_ADC) || (kind == ALU_SBC)) ? cin : 1'b0;

  assign sum9 = {1'b0, a_val} + {1'b0, b_val} + {8'd0, ci};
  assign sum5 = {1'b0, a_val[3:0]} + {1'b0, b_val[3:0]} + {4'd0, ci};
  assign dif9 = {1'b0, a_val} - {1'b0, b_val} - {8'd0, ci};
  assign dif5 = {1'b0, a_val[3:0]} - {1'b0, b_val[3:0]} - {4'd0, ci};

  always_comb begin
    r   = '0;
    f   = flags;
    res = '0;
    wb  = '0;
    unique case (beat.func)
      FUNC_ALU: begin
        unique case (kind)
          ALU_ADD, ALU_ADC: begin
            r = sum9[7:0];
            f = '{z: (r == 8'd0), n: 1'b0, h: sum5[4], c: sum9[8]};
          end
          ALU_SUB, ALU_SBC, ALU_CP: begin
            r = dif9[7:0];
            f = '{z: (r == 8'd0), n: 1'b1, h: dif5[4], c: dif9[8]};
          end
          ALU_AND: begin
            r = a_val & b_val;
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
          end
          ALU_XOR: begin
            r = a_val ^ b_val;
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
          end
          ALU_OR: begin
            r = a_val | b_val;
            f = '{z: (r == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
          end
          default: begin
            r = '0;
          end
        endcase
        res.dest         = REG_A;
        res.dest_written = (kind != ALU_CP);
        wb.reg_we        = (kind != ALU_CP);
        wb.reg_idx       = REG_A;
      end
      FUNC_INCDEC: begin
        if (src == KIND_INC) begin
          r = v_val + 8'd1;
          f = '{z: (r == 8'd0), n: 1'b0, h: (v_val[3:0] == 4'hF), c: flags.c};
        end else begin
          r = v_val - 8'd1;
          f = '{z: (r == 8'd0), n: 1'b1, h: (v_val[3:0] == 4'h0), c: flags.c};
        end
        res.dest         = kind;
        res.dest_written = 1'b1;
        res.mem_write    = (kind == REG_MEM);
        wb.reg_we        = (kind != REG_MEM);
        wb.reg_idx       = kind;
      end
      FUNC_LOAD_REG: begin
        r                = beat.mem_value;
        res.dest         = src;
        res.dest_written = (src != REG_MEM);
        wb.reg_we        = (src != REG_MEM);
        wb.reg_idx       = src;
      end
      FUNC_LOAD_FLG: begin
        r        = {beat.mem_value[7:4], 4'd0};
        f        = beat.mem_value[7:4];
        res.dest = REG_B;
      end
      default: begin
        r = '0;
      end
    endcase
    res.result     = r;
    res.zero_flag  = f.z;
    res.sub_flag   = f.n;
    res.half_flag  = f.h;
    res.carry_flag = f.c;
    wb.reg_data    = r;
    wb.flags       = f;
  end

endmodule

FILE: hw/rtl/cpu8_alu_with_register_file_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu8_alu_with_register_file_unit
// 8-bit ALU and INC/DEC unit with its own register file and Z/N/H/C flags.
// ----------------------------------------------------------------------------
// The unit accepts one input beat per clock while in_stall is low and
// returns exactly one result beat for every input beat, in order. The beat
// is captured in the input register when accepted, executed in one pass of
// combinational logic, and captured in the result register when that
// register can take it, and is then offered on the output.
// The register file and flags are updated at the same edge that loads the
// result register, so the next beat in the input register always sees the
// state its predecessor left and no forwarding is needed. Without stalls,
// the sustained rate is one beat per cycle, set by the single execute pass
// between the two registers. While the result register holds a waiting
// result, the input register can still take one more beat; once both are
// full, the input stall follows the output stall in the same cycle.
// ----------------------------------------------------------------------------
module cpu8_alu_with_register_file_unit
  import cpu8_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic       s1_valid;
  in_beat_t   s1_beat;
  logic       advance;
  logic       execute;
  logic [2:0] rd_idx;
  logic [7:0] rd_data;
  logic [7:0] a_data;
  flags_t     flags;
  out_beat_t  exec_res;
  wb_t        wb;

  // The result register can take a new beat when it is empty or being read.
  assign advance  = !out_valid || !out_stall;
  assign execute  = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_beat <= in_data;
    end
  end

  // INC/DEC names its target in bits 5..3; everything else reads bits 2..0.
  assign rd_idx = (s1_beat.func == FUNC_INCDEC) ? s1_beat.opcode[5:3]
                                                : s1_beat.opcode[2:0];

  cpu8_rf u_rf (
    .clk     (clk),
    .rst     (rst),
    .we      (execute),
    .wb      (wb),
    .rd_idx  (rd_idx),
    .rd_data (rd_data),
    .a_data  (a_data),
    .flags   (flags)
  );

  cpu8_exec u_exec (
    .beat    (s1_beat),
    .operand (rd_data),
    .a_val   (a_data),
    .flags   (flags),
    .res     (exec_res),
    .wb      (wb)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (execute) begin
      out_data <= exec_res;
    end
  end

endmodule
